/* src/gda_pkg.sv */
`default_nettype none
// package for the gregorian date add days unit
// field widths, calendar constants and the month length and leap helpers; no dependencies
package gda_pkg;

  localparam int ADD_WIDTH = 16;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int SYEAR_W = 12;
  localparam int NYEAR_W = 13;
  localparam int ADD_W   = 16;
  localparam int ORD_W   = 9;

  // count bits that take part in the walk
  localparam int ADD_BITS = (ADD_WIDTH < ADD_W) ? ADD_WIDTH : ADD_W;

  localparam int LEAP_CYCLE = 400;
  localparam int CENTURY    = 100;
  localparam int COMMON_LEN = 365;
  localparam int LEAP_LEN   = 366;

  localparam logic [MON_W-1:0] JAN = MON_W'(1);
  localparam logic [MON_W-1:0] FEB = MON_W'(2);
  localparam logic [MON_W-1:0] DEC = MON_W'(12);

  // r400 is the year modulo 400; its low two bits are the year modulo 4
  function automatic logic is_leap(input logic [8:0] r400);
    logic century;
    century = (r400 == 9'(CENTURY)) || (r400 == 9'(2 * CENTURY)) ||
              (r400 == 9'(3 * CENTURY));
    return (r400 == 9'd0) || (!century && (r400[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      4'd2: len = leap ? DAY_W'(29) : DAY_W'(28);
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

/* src/gda_if.sv */
`default_nettype none
// channel interfaces of the gregorian date add days unit
// depends on gda_pkg for the field widths
interface gda_in_if;
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DAY_W-1:0]   start_day;
  logic [gda_pkg::MON_W-1:0]   start_month;
  logic [gda_pkg::SYEAR_W-1:0] start_year;
  logic [gda_pkg::ADD_W-1:0]   day_count;

  modport source (output valid, start_day, start_month, start_year, day_count,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, day_count,
                output ready);
endinterface

interface gda_out_if;
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DAY_W-1:0]   new_day;
  logic [gda_pkg::MON_W-1:0]   new_month;
  logic [gda_pkg::NYEAR_W-1:0] new_year;
  logic [gda_pkg::ORD_W-1:0]   day_of_year;
  logic [gda_pkg::ORD_W-1:0]   days_left;
  logic                        date_invalid;

  modport source (output valid, new_day, new_month, new_year, day_of_year, days_left,
                  date_invalid, input ready);
  modport sink (input valid, new_day, new_month, new_year, day_of_year, days_left,
                date_invalid, output ready);
endinterface
`default_nettype wire

/* src/gregorian_date_add_days_unit.sv */
`default_nettype none
// gregorian date add days unit: top level with its sequencer and shared datapath
// depends on gda_pkg and the channel interfaces in gda_if
//
// takes one start date and a day count per word on req and returns one word on rsp:
// the date that many days later, the ordinal day of the start date and the days
// left in its year, or date_invalid with all other fields zero when the start day
// or month is out of range. one word is worked at a time; req.ready is high only
// while the sequencer idles, and the finished word sits in the rsp register so the
// next request can be taken while it waits. a word passes through the reduction of
// the year modulo 400, a range check, the ordinal-day walk over the months up to and
// including the start month, the month walk over each month crossed, and the post of
// the result. the month walk, one month per cycle through a single subtract and
// compare, sets how long a word takes. the leap rule tracks the year modulo 400 as
// the year rolls, so no divider is needed.
module gregorian_date_add_days_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  gda_in_if.sink     req,
  gda_out_if.source  rsp
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_CHECK = 6'b000100,
    S_DOY   = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // working registers
  logic [gda_pkg::DAY_W-1:0]    day;
  logic [gda_pkg::MON_W-1:0]    month;
  logic [gda_pkg::NYEAR_W-1:0]  year;
  logic [gda_pkg::SYEAR_W-1:0]  rem;      // year modulo 400 once reduced
  logic [gda_pkg::ADD_BITS-1:0] add;
  logic [1:0]                   k;        // reduction step, 400 << k
  logic [gda_pkg::MON_W-1:0]    mw;       // month pointer of the ordinal walk
  logic [gda_pkg::ORD_W-1:0]    doy;
  logic [gda_pkg::ORD_W-1:0]    dleft;
  logic                         invalid;

  // shared datapath
  logic                         leap;
  logic [gda_pkg::SYEAR_W-1:0]  limit;
  logic [gda_pkg::DAY_W-1:0]    mlen_cur;
  logic [gda_pkg::DAY_W-1:0]    mlen_walk;
  logic [gda_pkg::DAY_W-1:0]    rest;
  logic [gda_pkg::ADD_BITS-1:0] rest_ext;
  logic                         rsp_free;

  assign leap      = gda_pkg::is_leap(rem[8:0]);
  assign limit     = gda_pkg::SYEAR_W'(gda_pkg::LEAP_CYCLE) << k;
  assign mlen_cur  = gda_pkg::month_len(month, leap);
  assign mlen_walk = gda_pkg::month_len(mw, leap);
  // days up to and including the last day of this month
  assign rest      = gda_pkg::DAY_W'(mlen_cur - day + gda_pkg::DAY_W'(1));
  assign rest_ext  = gda_pkg::ADD_BITS'(rest);
  assign rsp_free  = !rsp.valid || rsp.ready;

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // post a finished word, or drop the one the sink has taken
      if (state == S_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            day   <= req.start_day;
            month <= req.start_month;
            year  <= gda_pkg::NYEAR_W'(req.start_year);
            rem   <= req.start_year;
            add   <= req.day_count[gda_pkg::ADD_BITS-1:0];
            k     <= 2'd3;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // restoring reduction of the year modulo 400
          if (rem >= limit) begin
            rem <= rem - limit;
          end
          if (k == 2'd0) begin
            state <= S_CHECK;
          end else begin
            k <= k - 2'd1;
          end
        end
        S_CHECK: begin
          if (month < gda_pkg::JAN || month > gda_pkg::DEC ||
              day == '0 || day > mlen_cur) begin
            invalid <= 1'b1;
            state   <= S_DONE;
          end else begin
            invalid <= 1'b0;
            doy     <= gda_pkg::ORD_W'(day);
            mw      <= gda_pkg::JAN;
            state   <= S_DOY;
          end
        end
        S_DOY: begin
          if (mw == month) begin
            dleft <= (leap ? gda_pkg::ORD_W'(gda_pkg::LEAP_LEN)
                           : gda_pkg::ORD_W'(gda_pkg::COMMON_LEN)) - doy;
            state <= S_WALK;
          end else begin
            doy <= doy + gda_pkg::ORD_W'(mlen_walk);
            mw  <= mw + gda_pkg::MON_W'(1);
          end
        end
        S_WALK: begin
          if (add == '0) begin
            state <= S_DONE;
          end else if (add >= rest_ext) begin
            add <= add - rest_ext;
            day <= gda_pkg::DAY_W'(1);
            if (month == gda_pkg::DEC) begin
              month <= gda_pkg::JAN;
              year  <= year + gda_pkg::NYEAR_W'(1);
              rem   <= (rem == gda_pkg::SYEAR_W'(gda_pkg::LEAP_CYCLE - 1)) ? '0
                                                                           : rem + 1'b1;
            end else begin
              month <= month + gda_pkg::MON_W'(1);
            end
          end else begin
            // count ends inside this month
            day <= day + add[gda_pkg::DAY_W-1:0];
            add <= '0;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word register, loaded as the sequencer posts
  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp.date_invalid <= invalid;
      if (invalid) begin
        rsp.new_day     <= '0;
        rsp.new_month   <= '0;
        rsp.new_year    <= '0;
        rsp.day_of_year <= '0;
        rsp.days_left   <= '0;
      end else begin
        rsp.new_day     <= day;
        rsp.new_month   <= month;
        rsp.new_year    <= year;
        rsp.day_of_year <= doy;
        rsp.days_left   <= dleft;
      end
    end
  end

`ifndef SYNTH
  // a taken request starts the year reduction
  a_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_MOD))
    else $error("accepted word did not start the reduction");

  // the year residue stays reduced while the month walk runs
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (rem < gda_pkg::SYEAR_W'(gda_pkg::LEAP_CYCLE)))
    else $error("year residue out of range in month walk");

  // the walked day stays within its month
  a_day: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (day != '0 && day <= mlen_cur))
    else $error("walked day outside its month");

  // an invalid date posts zero fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.date_invalid) |-> (rsp.new_day == '0 && rsp.new_month == '0 &&
      rsp.new_year == '0 && rsp.day_of_year == '0 && rsp.days_left == '0))
    else $error("invalid date with nonzero fields");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
// self-checking bench for gregorian_date_add_days_unit: directed calendar corners, then
// random dates with random idling on both channels; depends on gda_pkg, gda_if and the unit
module tb;
  import gda_pkg::*;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MON_W-1:0]   month;
    logic [SYEAR_W-1:0] year;
    logic [ADD_W-1:0]   count;
  } start_date_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MON_W-1:0]   month;
    logic [NYEAR_W-1:0] year;
    logic [ORD_W-1:0]   ordinal;
    logic [ORD_W-1:0]   left;
    logic               invalid;
  } moved_date_t;

  logic clk = 1'b0;
  logic rst;

  gda_in_if  req ();
  gda_out_if rsp ();

  gregorian_date_add_days_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  // predicted result words, oldest first
  moved_date_t advanced_dates[$];
  int          bad_words = 0;
  bit          idle_on = 1'b1;

  function automatic bit leap_year(input int unsigned yr);
    if (yr % 400 == 0) return 1'b1;
    if (yr % 100 == 0) return 1'b0;
    return (yr % 4 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(yr) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // walk the calendar one month at a time, just as the unit is specified to
  function automatic moved_date_t advance_date(input start_date_t s);
    moved_date_t r;
    int unsigned day, mon, yr, togo, ord, rest, m;
    r    = '0;
    day  = s.day;
    mon  = s.month;
    yr   = s.year;
    togo = s.count & ((32'd1 << ADD_BITS) - 1);
    if (mon < JAN || mon > DEC || day < 1 || day > days_in_month(mon, yr)) begin
      r.invalid = 1'b1;
      return r;
    end
    ord = day;
    for (m = JAN; m < mon; m++) ord += days_in_month(m, yr);
    r.ordinal = ORD_W'(ord);
    r.left    = ORD_W'((leap_year(yr) ? LEAP_LEN : COMMON_LEN) - ord);
    while (togo > 0) begin
      rest = days_in_month(mon, yr) - day + 1;
      if (togo >= rest) begin
        togo -= rest;
        day = 1;
        if (mon == DEC) begin
          mon = JAN;
          yr++;
        end else begin
          mon++;
        end
      end else begin
        day += togo;
        togo = 0;
      end
    end
    r.day   = DAY_W'(day);
    r.month = MON_W'(mon);
    r.year  = NYEAR_W'(yr);
    return r;
  endfunction

  // offer one word on req, with an optional random gap before it
  task automatic send_date(input int unsigned day, input int unsigned mon,
                           input int unsigned yr, input int unsigned count);
    start_date_t s;
    moved_date_t want;
    s.day   = DAY_W'(day);
    s.month = MON_W'(mon);
    s.year  = SYEAR_W'(yr);
    s.count = ADD_W'(count);
    want    = advance_date(s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.start_day   <= s.day;
    req.start_month <= s.month;
    req.start_year  <= s.year;
    req.day_count   <= s.count;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    advanced_dates.push_back(want);
  endtask

  // response side backpressure
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin
    moved_date_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.new_day, rsp.new_month, rsp.new_year, rsp.day_of_year, rsp.days_left,
              rsp.date_invalid};
      if (advanced_dates.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: day %0d month %0d year %0d ord %0d left %0d inv %0d",
                   got.day, got.month, got.year, got.ordinal, got.left, got.invalid);
      end else begin
        want = advanced_dates.pop_front();
        if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
            got.ordinal !== want.ordinal || got.left !== want.left ||
            got.invalid !== want.invalid) begin
          bad_words++;
          if (bad_words <= 10)
            $display({"mismatch: expected %0d/%0d/%0d ord %0d left %0d inv %0d, ",
                      "got %0d/%0d/%0d ord %0d left %0d inv %0d"},
                     want.day, want.month, want.year, want.ordinal, want.left, want.invalid,
                     got.day, got.month, got.year, got.ordinal, got.left, got.invalid);
        end
      end
    end
  end

  // out of range day or month, including february 29 in common years
  task automatic test_invalid_dates();
    send_date(0, JAN, 2023, 5);
    send_date(1, 0, 2023, 5);
    send_date(1, 13, 2023, 5);
    send_date(31, 15, 4095, 65535);
    send_date(31, 4, 2023, 0);
    send_date(30, FEB, 2000, 1);
    send_date(29, FEB, 1900, 1);
    send_date(29, FEB, 2023, 0);
  endtask

  // leap rule corners, year wrap, zero count and the largest count
  task automatic test_calendar_corners();
    send_date(29, FEB, 0, 0);
    send_date(29, FEB, 2000, 1);
    send_date(28, FEB, 2100, 1);
    send_date(28, FEB, 2024, 1);
    send_date(31, JAN, 1999, 29);
    send_date(1, 3, 1600, 365);
    send_date(31, DEC, 4095, 1);
    send_date(31, DEC, 4095, 65535);
    send_date(1, JAN, 0, 65535);
    send_date(1, JAN, 0, 0);
    send_date(15, 6, 2024, 0);
    send_date(31, DEC, 1999, 0);
    send_date(30, 11, 2047, 2048);
  endtask

  // mostly short counts so the run stays quick; a few span the full count width
  function automatic int unsigned pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(0, 400);
    if (sel < 9) return $urandom_range(0, 4000);
    return $urandom_range(0, 65535);
  endfunction

  task automatic test_random_dates(input int n);
    int unsigned mon, yr, len, day;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        // raw fields, which may be out of range
        send_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 4095),
                  pick_count());
      end else begin
        mon = $urandom_range(JAN, DEC);
        yr  = $urandom_range(0, 4095);
        len = days_in_month(mon, yr);
        day = ($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len);
        send_date(day, mon, yr, pick_count());
      end
    end
  endtask

  initial begin
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.start_day   <= '0;
    req.start_month <= '0;
    req.start_year  <= '0;
    req.day_count   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_invalid_dates();
    test_calendar_corners();
    test_random_dates(210);
    // back to back with no idling on either side
    idle_on = 1'b0;
    test_random_dates(40);
    req.valid <= 1'b0;
    while (advanced_dates.size() != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
    bad_words += advanced_dates.size();
    if (bad_words == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
